>>> hw/rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, register codes, reset values and elaboration helpers for the
// Mandelbrot escape-time counter.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 4096;
  localparam int unsigned MAX_ROWS_DEF    = 4096;
  localparam int unsigned MAX_ITER_DEF    = 64;
  localparam int unsigned FRAC_BITS_DEF   = 28;

  localparam int unsigned IDX_W     = 12;
  localparam int unsigned REG_W     = 32;
  localparam int unsigned LIMIT_W   = 7;
  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_RE  = 3'd0,
    REG_ORIGIN_IM  = 3'd1,
    REG_STEP_RE    = 3'd2,
    REG_STEP_IM    = 3'd3,
    REG_ITER_LIMIT = 3'd4
  } cfg_reg_t;

  localparam logic [REG_W-1:0]   ORIGIN_RE_RST  = 32'hE000_0000;
  localparam logic [REG_W-1:0]   ORIGIN_IM_RST  = 32'hF000_0000;
  localparam logic [REG_W-1:0]   STEP_RE_RST    = 32'h0010_0000;
  localparam logic [REG_W-1:0]   STEP_IM_RST    = 32'h0008_0000;
  localparam logic [LIMIT_W-1:0] ITER_LIMIT_RST = 7'd10;

  typedef struct packed {
    logic [REG_W-1:0]   origin_re;
    logic [REG_W-1:0]   origin_im;
    logic [REG_W-1:0]   step_re;
    logic [REG_W-1:0]   step_im;
    logic [LIMIT_W-1:0] iter_limit;
  } cfg_t;

  // Control that travels with every pixel through the pipeline.
  typedef struct packed {
    logic valid;
    logic done;
  } ctl_t;

  // Number of conditional subtractions needed to bring a 12-bit index below m.
  function automatic int unsigned red_steps(int unsigned m);
    int unsigned n;
    n = 0;
    for (int unsigned j = 0; j < IDX_W; j++) begin
      if ((m << j) <= (2 ** IDX_W - 1)) begin
        n++;
      end
    end
    return n;
  endfunction

  function automatic int unsigned idx_width(int unsigned m);
    int unsigned w;
    w = $clog2(m);
    return (w < IDX_W) ? w : IDX_W;
  endfunction

endpackage

>>> hw/rtl/mbe_cfg_regs.sv
// ----------------------------------------------------------------------------
// mbe_cfg_regs
// Configuration register file: origin, steps and iteration limit.
// ----------------------------------------------------------------------------
module mbe_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbe_pkg::REG_W-1:0]       cfg_data,
  output mbe_pkg::cfg_t                   cfg
);

  mbe_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_re  <= mbe_pkg::ORIGIN_RE_RST;
      cfg_r.origin_im  <= mbe_pkg::ORIGIN_IM_RST;
      cfg_r.step_re    <= mbe_pkg::STEP_RE_RST;
      cfg_r.step_im    <= mbe_pkg::STEP_IM_RST;
      cfg_r.iter_limit <= mbe_pkg::ITER_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbe_pkg::REG_ORIGIN_RE:  cfg_r.origin_re  <= cfg_data;
        mbe_pkg::REG_ORIGIN_IM:  cfg_r.origin_im  <= cfg_data;
        mbe_pkg::REG_STEP_RE:    cfg_r.step_re    <= cfg_data;
        mbe_pkg::REG_STEP_IM:    cfg_r.step_im    <= cfg_data;
        mbe_pkg::REG_ITER_LIMIT: cfg_r.iter_limit <= cfg_data[mbe_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/mbe_point.sv
// ----------------------------------------------------------------------------
// mbe_point
// Front end: wraps the pixel indices, forms c = origin + index * step and
// flags points that lie outside the radius-two square.
// ----------------------------------------------------------------------------
module mbe_point #(
  parameter int unsigned MAX_COLUMNS = mbe_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = mbe_pkg::MAX_ROWS_DEF,
  parameter int unsigned FRAC_BITS   = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [mbe_pkg::IDX_W-1:0]           in_column,
  input  logic [mbe_pkg::IDX_W-1:0]           in_row,
  input  mbe_pkg::cfg_t                       cfg,
  output mbe_pkg::ctl_t                       ctl,
  output logic signed [FRAC_BITS+2:0]         c_re,
  output logic signed [FRAC_BITS+2:0]         c_im
);

  localparam int unsigned IDX_W     = mbe_pkg::IDX_W;
  localparam int unsigned REG_W     = mbe_pkg::REG_W;
  localparam int unsigned C_W       = FRAC_BITS + 3;
  localparam int unsigned COL_STEPS = mbe_pkg::red_steps(MAX_COLUMNS);
  localparam int unsigned ROW_STEPS = mbe_pkg::red_steps(MAX_ROWS);
  localparam int unsigned RED_N     = (COL_STEPS > ROW_STEPS) ? COL_STEPS : ROW_STEPS;
  localparam int unsigned COL_W     = mbe_pkg::idx_width(MAX_COLUMNS);
  localparam int unsigned ROW_W     = mbe_pkg::idx_width(MAX_ROWS);
  localparam int unsigned PRE_W     = REG_W + COL_W + 1;
  localparam int unsigned PIM_W     = REG_W + ROW_W + 1;
  localparam int unsigned SRE_W     = PRE_W + 1;
  localparam int unsigned SIM_W     = PIM_W + 1;
  localparam logic signed [SRE_W-1:0] TWO_RE = SRE_W'(1) << (FRAC_BITS + 1);
  localparam logic signed [SIM_W-1:0] TWO_IM = SIM_W'(1) << (FRAC_BITS + 1);

  // Index wrap: one conditional subtraction of a shifted bound per stage.
  logic [IDX_W-1:0] col_red [0:RED_N];
  logic [IDX_W-1:0] row_red [0:RED_N];
  logic             vld_red [0:RED_N];

  assign col_red[0] = in_column;
  assign row_red[0] = in_row;
  assign vld_red[0] = in_valid;

  for (genvar s = 0; s < RED_N; s++) begin : g_red
    logic [IDX_W-1:0] col_r, col_nxt;
    logic [IDX_W-1:0] row_r, row_nxt;
    logic             vld_r;

    if (s < COL_STEPS) begin : g_col
      localparam logic [IDX_W-1:0] SUB = IDX_W'(MAX_COLUMNS << (COL_STEPS - 1 - s));
      assign col_nxt = (col_red[s] >= SUB) ? col_red[s] - SUB : col_red[s];
    end else begin : g_col_pass
      assign col_nxt = col_red[s];
    end

    if (s < ROW_STEPS) begin : g_row
      localparam logic [IDX_W-1:0] SUB = IDX_W'(MAX_ROWS << (ROW_STEPS - 1 - s));
      assign row_nxt = (row_red[s] >= SUB) ? row_red[s] - SUB : row_red[s];
    end else begin : g_row_pass
      assign row_nxt = row_red[s];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_red[s];
      end
    end

    always_ff @(posedge clk) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end

    assign col_red[s+1] = col_r;
    assign row_red[s+1] = row_r;
    assign vld_red[s+1] = vld_r;
  end

  logic [COL_W-1:0] col_w;
  logic [ROW_W-1:0] row_w;

  assign col_w = col_red[RED_N][COL_W-1:0];
  assign row_w = row_red[RED_N][ROW_W-1:0];

  // Products of index and step.
  logic                    prod_vld_r;
  logic signed [PRE_W-1:0] prod_re_r, prod_re_nxt;
  logic signed [PIM_W-1:0] prod_im_r, prod_im_nxt;

  assign prod_re_nxt = PRE_W'($signed({1'b0, col_w})) * PRE_W'($signed(cfg.step_re));
  assign prod_im_nxt = PIM_W'($signed({1'b0, row_w})) * PIM_W'($signed(cfg.step_im));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= vld_red[RED_N];
    end
  end

  always_ff @(posedge clk) begin
    prod_re_r <= prod_re_nxt;
    prod_im_r <= prod_im_nxt;
  end

  // Add the origin, still at full width.
  logic                    sum_vld_r;
  logic signed [SRE_W-1:0] sum_re_r, sum_re_nxt;
  logic signed [SIM_W-1:0] sum_im_r, sum_im_nxt;

  assign sum_re_nxt = SRE_W'(prod_re_r) + SRE_W'($signed(cfg.origin_re));
  assign sum_im_nxt = SIM_W'(prod_im_r) + SIM_W'($signed(cfg.origin_im));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else begin
      sum_vld_r <= prod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_re_r <= sum_re_nxt;
    sum_im_r <= sum_im_nxt;
  end

  // A point beyond two in either axis escapes at the first test, so it is
  // marked finished here and c may then be narrowed without loss.
  mbe_pkg::ctl_t          ctl_r, ctl_nxt;
  logic signed [C_W-1:0]  c_re_r, c_im_r;

  always_comb begin
    ctl_nxt.valid = sum_vld_r;
    ctl_nxt.done  = (sum_re_r > TWO_RE) || (sum_re_r < -TWO_RE) ||
                    (sum_im_r > TWO_IM) || (sum_im_r < -TWO_IM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_re_r <= sum_re_r[C_W-1:0];
    c_im_r <= sum_im_r[C_W-1:0];
  end

  assign ctl  = ctl_r;
  assign c_re = c_re_r;
  assign c_im = c_im_r;

endmodule

>>> hw/rtl/mbe_iter.sv
// ----------------------------------------------------------------------------
// mbe_iter
// One unrolled iteration z = z*z + c in three register stages: bound test and
// products, magnitude compare and floor, then the add of c and the count.
// ----------------------------------------------------------------------------
module mbe_iter #(
  parameter int unsigned FRAC_BITS = mbe_pkg::FRAC_BITS_DEF,
  parameter int unsigned MAX_ITER  = mbe_pkg::MAX_ITER_DEF,
  parameter int unsigned STAGE     = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [mbe_pkg::LIMIT_W-1:0]         iter_limit,
  input  mbe_pkg::ctl_t                       ctl_in,
  input  logic signed [FRAC_BITS+2:0]         c_re_in,
  input  logic signed [FRAC_BITS+2:0]         c_im_in,
  input  logic signed [FRAC_BITS+4:0]         z_re_in,
  input  logic signed [FRAC_BITS+4:0]         z_im_in,
  input  logic [$clog2(MAX_ITER+1)-1:0]       count_in,
  output mbe_pkg::ctl_t                       ctl_out,
  output logic signed [FRAC_BITS+2:0]         c_re_out,
  output logic signed [FRAC_BITS+2:0]         c_im_out,
  output logic signed [FRAC_BITS+4:0]         z_re_out,
  output logic signed [FRAC_BITS+4:0]         z_im_out,
  output logic [$clog2(MAX_ITER+1)-1:0]       count_out
);

  localparam int unsigned LIMIT_W = mbe_pkg::LIMIT_W;
  localparam int unsigned C_W     = FRAC_BITS + 3;
  localparam int unsigned Z_W     = FRAC_BITS + 5;
  localparam int unsigned M_W     = FRAC_BITS + 3;
  localparam int unsigned P_W     = 2 * M_W;
  localparam int unsigned S_W     = P_W + 1;
  localparam int unsigned CNT_W   = $clog2(MAX_ITER + 1);
  localparam bit          STAGE_OVER = (STAGE >= 2 ** LIMIT_W);
  localparam logic signed [Z_W-1:0] TWO  = Z_W'(1) << (FRAC_BITS + 1);
  localparam logic signed [S_W-1:0] FOUR = S_W'(1) << (2 * FRAC_BITS + 2);
  localparam logic [CNT_W-1:0]      NEXT_COUNT = CNT_W'(STAGE + 1);

  // Stage 1: bound test and the three products. Once the bound test passes
  // both components fit the narrow operand width.
  mbe_pkg::ctl_t         ctl1_r;
  logic                  hit1_r, hit1_nxt;
  logic signed [M_W-1:0] zr_m, zi_m;
  logic signed [P_W-1:0] sr1_r, si1_r, p1_r;
  logic signed [C_W-1:0] c_re1_r, c_im1_r;
  logic [CNT_W-1:0]      count1_r;
  logic                  limit_hit;

  assign zr_m      = z_re_in[M_W-1:0];
  assign zi_m      = z_im_in[M_W-1:0];
  assign limit_hit = STAGE_OVER || (LIMIT_W'(STAGE) >= iter_limit);
  assign hit1_nxt  = limit_hit ||
                     (z_re_in > TWO) || (z_re_in < -TWO) ||
                     (z_im_in > TWO) || (z_im_in < -TWO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    hit1_r   <= hit1_nxt;
    sr1_r    <= P_W'(zr_m) * P_W'(zr_m);
    si1_r    <= P_W'(zi_m) * P_W'(zi_m);
    p1_r     <= P_W'(zr_m) * P_W'(zi_m);
    c_re1_r  <= c_re_in;
    c_im1_r  <= c_im_in;
    count1_r <= count_in;
  end

  // Stage 2: magnitude compare, then the floor to the working precision,
  // which is an arithmetic right shift.
  mbe_pkg::ctl_t         ctl2_r, ctl2_nxt;
  logic signed [S_W-1:0] mag, nr, ni;
  logic signed [S_W-1:0] nr_sh, ni_sh;
  logic signed [Z_W-1:0] nr2_r, ni2_r;
  logic signed [C_W-1:0] c_re2_r, c_im2_r;
  logic [CNT_W-1:0]      count2_r;

  assign mag   = S_W'(sr1_r) + S_W'(si1_r);
  assign nr    = S_W'(sr1_r) - S_W'(si1_r);
  assign ni    = S_W'(p1_r) <<< 1;
  assign nr_sh = nr >>> FRAC_BITS;
  assign ni_sh = ni >>> FRAC_BITS;

  always_comb begin
    ctl2_nxt.valid = ctl1_r.valid;
    ctl2_nxt.done  = ctl1_r.done || hit1_r || (mag > FOUR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= ctl2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nr2_r    <= nr_sh[Z_W-1:0];
    ni2_r    <= ni_sh[Z_W-1:0];
    c_re2_r  <= c_re1_r;
    c_im2_r  <= c_im1_r;
    count2_r <= count1_r;
  end

  // Stage 3: add c and advance the count while the pixel is still running.
  mbe_pkg::ctl_t         ctl3_r;
  logic signed [Z_W-1:0] z_re3_r, z_im3_r;
  logic signed [C_W-1:0] c_re3_r, c_im3_r;
  logic [CNT_W-1:0]      count3_r, count3_nxt;

  assign count3_nxt = ctl2_r.done ? count2_r : NEXT_COUNT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else begin
      ctl3_r <= ctl2_r;
    end
  end

  always_ff @(posedge clk) begin
    z_re3_r  <= Z_W'(c_re2_r) + nr2_r;
    z_im3_r  <= Z_W'(c_im2_r) + ni2_r;
    c_re3_r  <= c_re2_r;
    c_im3_r  <= c_im2_r;
    count3_r <= count3_nxt;
  end

  assign ctl_out   = ctl3_r;
  assign c_re_out  = c_re3_r;
  assign c_im_out  = c_im3_r;
  assign z_re_out  = z_re3_r;
  assign z_im_out  = z_im3_r;
  assign count_out = count3_r;

endmodule

>>> hw/rtl/mandelbrot_escape_count.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_count
// Escape-time counter for one pixel per clock, fully unrolled pipeline.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock at which start is high; busy is always low.
// Its result appears on out_escape_count with out_valid high for exactly one
// cycle, in the order the pixels came in; the receiver cannot hold it off and
// need not. On its way a pixel passes the index-wrap stages, which exist only
// when MAX_COLUMNS or MAX_ROWS is below 4096, then the product, origin-add and
// bound-flag registers of the front end, then the three register stages of
// each unrolled iteration: products, magnitude compare, and the add of c.
// Configuration should be written only while no pixel is in flight.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count #(
  parameter int unsigned MAX_COLUMNS = mbe_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = mbe_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_ITER    = mbe_pkg::MAX_ITER_DEF,
  parameter int unsigned FRAC_BITS   = mbe_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [mbe_pkg::IDX_W-1:0]         in_column,
  input  logic [mbe_pkg::IDX_W-1:0]         in_row,
  output logic                              out_valid,
  output logic [mbe_pkg::COUNT_W-1:0]       out_escape_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbe_pkg::REG_W-1:0]         cfg_data
);

  localparam int unsigned C_W   = FRAC_BITS + 3;
  localparam int unsigned Z_W   = FRAC_BITS + 5;
  localparam int unsigned CNT_W = $clog2(MAX_ITER + 1);
  localparam int unsigned OUT_W = mbe_pkg::COUNT_W;

  mbe_pkg::cfg_t cfg;

  mbe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign busy = 1'b0;

  mbe_pkg::ctl_t         ctl_s   [0:MAX_ITER];
  logic signed [C_W-1:0] c_re_s  [0:MAX_ITER];
  logic signed [C_W-1:0] c_im_s  [0:MAX_ITER];
  logic signed [Z_W-1:0] z_re_s  [0:MAX_ITER];
  logic signed [Z_W-1:0] z_im_s  [0:MAX_ITER];
  logic [CNT_W-1:0]      count_s [0:MAX_ITER];

  mbe_point #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_point (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_column (in_column),
    .in_row    (in_row),
    .cfg       (cfg),
    .ctl       (ctl_s[0]),
    .c_re      (c_re_s[0]),
    .c_im      (c_im_s[0])
  );

  // The iteration starts from z = c with nothing counted.
  assign z_re_s[0]  = Z_W'(c_re_s[0]);
  assign z_im_s[0]  = Z_W'(c_im_s[0]);
  assign count_s[0] = '0;

  for (genvar k = 0; k < MAX_ITER; k++) begin : g_iter
    mbe_iter #(
      .FRAC_BITS (FRAC_BITS),
      .MAX_ITER  (MAX_ITER),
      .STAGE     (k)
    ) u_iter (
      .clk        (clk),
      .rst_n      (rst_n),
      .iter_limit (cfg.iter_limit),
      .ctl_in     (ctl_s[k]),
      .c_re_in    (c_re_s[k]),
      .c_im_in    (c_im_s[k]),
      .z_re_in    (z_re_s[k]),
      .z_im_in    (z_im_s[k]),
      .count_in   (count_s[k]),
      .ctl_out    (ctl_s[k+1]),
      .c_re_out   (c_re_s[k+1]),
      .c_im_out   (c_im_s[k+1]),
      .z_re_out   (z_re_s[k+1]),
      .z_im_out   (z_im_s[k+1]),
      .count_out  (count_s[k+1])
    );
  end

  assign out_valid        = ctl_s[MAX_ITER].valid;
  assign out_escape_count = OUT_W'(count_s[MAX_ITER]);

endmodule
